### hdl/dda_rwh_pkg.sv
// Shared constants, types and helpers of the grid ray caster.
package dda_rwh_pkg;

  // Map geometry and fixed-point format.
  localparam int MAP_WIDTH  = 64;
  localparam int MAP_HEIGHT = 64;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_CELLS  = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W     = $clog2(NUM_CELLS);

  // Field widths.
  localparam int CELL_W     = 6;
  localparam int CMP_W      = 9;
  localparam int DIST_W     = 32;
  localparam int POS_W      = 22;
  localparam int SH_W       = 12;
  localparam int STEPS_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Divider: numerator is screen height shifted up by the fraction bits.
  localparam int NUM_W      = SH_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(NUM_W);

  // Register indices of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS     = 1'd1;

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_HIT     = 2'd1,
    ST_NO_WALL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SIDE_NORTH = 2'd0,
    SIDE_SOUTH = 2'd1,
    SIDE_WEST  = 2'd2,
    SIDE_EAST  = 2'd3
  } side_t;

  // Linear address of a map cell, row major.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] col,
                                                  input logic [CELL_W-1:0] row);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAP_WIDTH)) + ADDR_W'(col);
    return a;
  endfunction

  // True when a cell lies inside the map.
  function automatic logic in_map(input logic [CELL_W-1:0] col,
                                  input logic [CELL_W-1:0] row);
    logic ok;
    ok = (CMP_W'(col) < CMP_W'(MAP_WIDTH)) && (CMP_W'(row) < CMP_W'(MAP_HEIGHT));
    return ok;
  endfunction

endpackage

### hdl/dda_rwh_if.sv
// Word channels of the ray caster: the item channel and the result channel.
interface dda_rwh_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [dda_rwh_pkg::CELL_W-1:0]      cell_x;
  logic [dda_rwh_pkg::CELL_W-1:0]      cell_y;
  logic                                cell_is_wall;
  logic                                step_x_negative;
  logic                                step_y_negative;
  logic [dda_rwh_pkg::DIST_W-1:0]      side_dist_x;
  logic [dda_rwh_pkg::DIST_W-1:0]      side_dist_y;
  logic [dda_rwh_pkg::DIST_W-1:0]      delta_dist_x;
  logic [dda_rwh_pkg::DIST_W-1:0]      delta_dist_y;
  logic [dda_rwh_pkg::POS_W-1:0]       player_x;
  logic [dda_rwh_pkg::POS_W-1:0]       player_y;

  modport source (
    output valid, action, cell_x, cell_y, cell_is_wall, step_x_negative,
           step_y_negative, side_dist_x, side_dist_y, delta_dist_x, delta_dist_y,
           player_x, player_y,
    input  ready
  );
  modport sink (
    input  valid, action, cell_x, cell_y, cell_is_wall, step_x_negative,
           step_y_negative, side_dist_x, side_dist_y, delta_dist_x, delta_dist_y,
           player_x, player_y,
    output ready
  );
endinterface

interface dda_rwh_out_if;
  logic                                valid;
  logic                                ready;
  dda_rwh_pkg::status_t                status;
  dda_rwh_pkg::side_t                  hit_face;
  logic [dda_rwh_pkg::DIST_W-1:0]      perp_distance;
  logic [dda_rwh_pkg::HEIGHT_W-1:0]    column_height;
  logic [dda_rwh_pkg::CELL_W-1:0]      hit_x;
  logic [dda_rwh_pkg::CELL_W-1:0]      hit_y;

  modport source (
    output valid, status, hit_face, perp_distance, column_height, hit_x, hit_y,
    input  ready
  );
  modport sink (
    input  valid, status, hit_face, perp_distance, column_height, hit_x, hit_y,
    output ready
  );
endinterface

### hdl/dda_rwh_ram.sv
// Generic single-port RAM with a registered read.
module dda_rwh_ram #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/dda_ray_wall_hit_top.sv
// Top level of the grid ray caster: map memory, DDA walker and height divider.
//
// Usage. The block holds a 64 by 64 map of wall bits in a single-port RAM.
// Words arrive on in_ch (valid/ready). A word with action 0 writes one map
// cell; a word with action 1 casts a ray from a start cell. Every word yields
// exactly one result word on out_ch (valid/ready), in order. The registers
// screen_height (index 0) and max_steps (index 1) go through cfg_we, cfg_index
// and cfg_data; the user must write them only when idle; the block won't check.
//
// Timing. A map write reaches the result register from S_FIN, the state after
// acceptance. A cast tests one grid cell per cycle, as the walker reads the map
// RAM at the next cell in the same cycle as it decides the step. A cast that
// hits a wall passes through the walk, a state for the distance and face, one
// to load the divider, the restoring divider (one quotient bit per cycle) and
// one to hand over the result. A cast that ends without a wall skips the
// divider. One item is worked on at a time; in_ch.ready is high only when idle.
// Reset. After rst_n the map RAM is swept to open, one cell per cycle, with
// in_ch.ready low throughout; configuration writes are still taken.
// If the receiver stalls, the result waits in the output register and a
// finished next result waits until that is taken.
module dda_ray_wall_hit_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dda_rwh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dda_rwh_pkg::CFG_DATA_W-1:0]  cfg_data,
  dda_rwh_in_if.sink                          in_ch,
  dda_rwh_out_if.source                       out_ch
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WALK  = 7'b0000100,
    S_DIST  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_INIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [dda_rwh_pkg::SH_W-1:0]    screen_h_r;
  logic [dda_rwh_pkg::STEPS_W-1:0] max_steps_r;

  // Clearing sweep.
  logic [dda_rwh_pkg::ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;

  // Walk state of the current cast.
  logic [dda_rwh_pkg::CELL_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [dda_rwh_pkg::DIST_W-1:0]  run_x_r, run_x_nxt, run_y_r, run_y_nxt;
  logic [dda_rwh_pkg::DIST_W-1:0]  ddx_r, ddx_nxt, ddy_r, ddy_nxt;
  logic [dda_rwh_pkg::POS_W-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic                            sxn_r, sxn_nxt, syn_r, syn_nxt;
  logic                            last_y_r, last_y_nxt;
  logic [dda_rwh_pkg::STEPS_W-1:0] steps_r, steps_nxt;

  // Hit result and divider.
  logic [dda_rwh_pkg::DIST_W-1:0]  dist_r, dist_nxt;
  dda_rwh_pkg::side_t              side_r, side_nxt;
  dda_rwh_pkg::status_t            res_st_r, res_st_nxt;
  logic [dda_rwh_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [dda_rwh_pkg::NUM_W-1:0]   quo_r, quo_nxt;
  logic [dda_rwh_pkg::DIST_W-1:0]  rem_r, rem_nxt;
  logic [dda_rwh_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // Output register.
  logic                             out_valid_r, out_valid_nxt;
  dda_rwh_pkg::status_t             out_st_r, out_st_nxt;
  dda_rwh_pkg::side_t               out_side_r, out_side_nxt;
  logic [dda_rwh_pkg::DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic [dda_rwh_pkg::HEIGHT_W-1:0] out_h_r, out_h_nxt;
  logic [dda_rwh_pkg::CELL_W-1:0]   out_hx_r, out_hx_nxt, out_hy_r, out_hy_nxt;

  // Map RAM port.
  logic                             ram_we;
  logic [dda_rwh_pkg::ADDR_W-1:0]   ram_addr;
  logic                             ram_wdata;
  logic                             ram_rdata;
  logic [dda_rwh_pkg::CELL_W-1:0]   rd_col, rd_row;

  // Step datapath.
  logic                             in_acc;
  logic                             x_first;
  logic                             edge_x, edge_y;
  logic [dda_rwh_pkg::DIST_W:0]     sum_x, sum_y;
  logic [dda_rwh_pkg::DIST_W:0]     rem_sh;
  logic                             out_free;

  dda_rwh_ram #(
    .DATA_W (1),
    .DEPTH  (dda_rwh_pkg::NUM_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign x_first = run_x_r < run_y_r;
  assign edge_x  = sxn_r ? (col_r == '0)
                         : (dda_rwh_pkg::CMP_W'(col_r) >=
                            dda_rwh_pkg::CMP_W'(dda_rwh_pkg::MAP_WIDTH - 1));
  assign edge_y  = syn_r ? (row_r == '0)
                         : (dda_rwh_pkg::CMP_W'(row_r) >=
                            dda_rwh_pkg::CMP_W'(dda_rwh_pkg::MAP_HEIGHT - 1));
  assign sum_x   = {1'b0, run_x_r} + {1'b0, ddx_r};
  assign sum_y   = {1'b0, run_y_r} + {1'b0, ddy_r};

  // One restoring division step: bring down the next numerator bit.
  assign rem_sh  = {rem_r, num_r[dda_rwh_pkg::NUM_W-1]};

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    run_x_nxt     = run_x_r;
    run_y_nxt     = run_y_r;
    ddx_nxt       = ddx_r;
    ddy_nxt       = ddy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    sxn_nxt       = sxn_r;
    syn_nxt       = syn_r;
    last_y_nxt    = last_y_r;
    steps_nxt     = steps_r;
    dist_nxt      = dist_r;
    side_nxt      = side_r;
    res_st_nxt    = res_st_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt    = out_st_r;
    out_side_nxt  = out_side_r;
    out_dist_nxt  = out_dist_r;
    out_h_nxt     = out_h_r;
    out_hx_nxt    = out_hx_r;
    out_hy_nxt    = out_hy_r;
    ram_we        = 1'b0;
    ram_wdata     = 1'b0;
    rd_col        = col_r;
    rd_row        = row_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == dda_rwh_pkg::ADDR_W'(dda_rwh_pkg::NUM_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // The RAM looks up the start cell so that the walk begins next cycle.
        rd_col = in_ch.cell_x;
        rd_row = in_ch.cell_y;
        if (in_acc) begin
          if (!in_ch.action) begin
            ram_we     = dda_rwh_pkg::in_map(in_ch.cell_x, in_ch.cell_y);
            ram_wdata  = in_ch.cell_is_wall;
            res_st_nxt = dda_rwh_pkg::ST_WRITTEN;
            state_nxt  = S_FIN;
          end else begin
            col_nxt    = in_ch.cell_x;
            row_nxt    = in_ch.cell_y;
            run_x_nxt  = in_ch.side_dist_x;
            run_y_nxt  = in_ch.side_dist_y;
            ddx_nxt    = in_ch.delta_dist_x;
            ddy_nxt    = in_ch.delta_dist_y;
            px_nxt     = in_ch.player_x;
            py_nxt     = in_ch.player_y;
            sxn_nxt    = in_ch.step_x_negative;
            syn_nxt    = in_ch.step_y_negative;
            last_y_nxt = 1'b0;
            steps_nxt  = '0;
            if (dda_rwh_pkg::in_map(in_ch.cell_x, in_ch.cell_y)) begin
              state_nxt = S_WALK;
            end else begin
              res_st_nxt = dda_rwh_pkg::ST_NO_WALL;
              state_nxt  = S_FIN;
            end
          end
        end
      end

      S_WALK: begin
        // ram_rdata holds the wall bit of the current cell.
        priority if (ram_rdata) begin
          state_nxt = S_DIST;
        end else if (steps_r >= max_steps_r) begin
          res_st_nxt = dda_rwh_pkg::ST_NO_WALL;
          state_nxt  = S_FIN;
        end else if (x_first) begin
          if (edge_x) begin
            res_st_nxt = dda_rwh_pkg::ST_NO_WALL;
            state_nxt  = S_FIN;
          end else begin
            col_nxt    = sxn_r ? col_r - 1'b1 : col_r + 1'b1;
            rd_col     = col_nxt;
            run_x_nxt  = sum_x[dda_rwh_pkg::DIST_W] ? '1 : sum_x[dda_rwh_pkg::DIST_W-1:0];
            last_y_nxt = 1'b0;
            steps_nxt  = steps_r + 1'b1;
          end
        end else begin
          if (edge_y) begin
            res_st_nxt = dda_rwh_pkg::ST_NO_WALL;
            state_nxt  = S_FIN;
          end else begin
            row_nxt    = syn_r ? row_r - 1'b1 : row_r + 1'b1;
            rd_row     = row_nxt;
            run_y_nxt  = sum_y[dda_rwh_pkg::DIST_W] ? '1 : sum_y[dda_rwh_pkg::DIST_W-1:0];
            last_y_nxt = 1'b1;
            steps_nxt  = steps_r + 1'b1;
          end
        end
      end

      S_DIST: begin
        // Perpendicular distance is the running side distance of the last
        // stepped axis less one delta, clipped at zero.
        if (last_y_r) begin
          dist_nxt = (run_y_r >= ddy_r) ? run_y_r - ddy_r : '0;
          side_nxt = ({row_r, {dda_rwh_pkg::FRAC_BITS{1'b0}}} < py_r) ?
                     dda_rwh_pkg::SIDE_NORTH : dda_rwh_pkg::SIDE_SOUTH;
        end else begin
          dist_nxt = (run_x_r >= ddx_r) ? run_x_r - ddx_r : '0;
          side_nxt = ({col_r, {dda_rwh_pkg::FRAC_BITS{1'b0}}} < px_r) ?
                     dda_rwh_pkg::SIDE_WEST : dda_rwh_pkg::SIDE_EAST;
        end
        state_nxt = S_INIT;
      end

      S_INIT: begin
        num_nxt     = {screen_h_r, {dda_rwh_pkg::FRAC_BITS{1'b0}}};
        quo_nxt     = '0;
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        res_st_nxt  = dda_rwh_pkg::ST_HIT;
        state_nxt   = S_DIV;
      end

      S_DIV: begin
        // A zero distance makes every quotient bit one, which saturates.
        if (rem_sh >= {1'b0, dist_r}) begin
          rem_nxt = dda_rwh_pkg::DIST_W'(rem_sh - {1'b0, dist_r});
          quo_nxt = {quo_r[dda_rwh_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[dda_rwh_pkg::DIST_W-1:0];
          quo_nxt = {quo_r[dda_rwh_pkg::NUM_W-2:0], 1'b0};
        end
        num_nxt     = {num_r[dda_rwh_pkg::NUM_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == dda_rwh_pkg::DIV_CNT_W'(dda_rwh_pkg::NUM_W - 1)) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          if (res_st_r == dda_rwh_pkg::ST_HIT) begin
            out_side_nxt = side_r;
            out_dist_nxt = dist_r;
            out_h_nxt    = (|quo_r[dda_rwh_pkg::NUM_W-1:dda_rwh_pkg::HEIGHT_W]) ?
                           '1 : quo_r[dda_rwh_pkg::HEIGHT_W-1:0];
            out_hx_nxt   = col_r;
            out_hy_nxt   = row_r;
          end else begin
            out_side_nxt = dda_rwh_pkg::SIDE_NORTH;
            out_dist_nxt = '0;
            out_h_nxt    = '0;
            out_hx_nxt   = '0;
            out_hy_nxt   = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign ram_addr = (state_r == S_CLEAR) ? clr_cnt_r : dda_rwh_pkg::cell_addr(rd_col, rd_row);

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      screen_h_r  <= dda_rwh_pkg::SH_W'(720);
      max_steps_r <= dda_rwh_pkg::STEPS_W'(128);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dda_rwh_pkg::REG_SCREEN_HEIGHT: screen_h_r  <= cfg_data[dda_rwh_pkg::SH_W-1:0];
          dda_rwh_pkg::REG_MAX_STEPS:     max_steps_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    run_x_r    <= run_x_nxt;
    run_y_r    <= run_y_nxt;
    ddx_r      <= ddx_nxt;
    ddy_r      <= ddy_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    sxn_r      <= sxn_nxt;
    syn_r      <= syn_nxt;
    last_y_r   <= last_y_nxt;
    steps_r    <= steps_nxt;
    dist_r     <= dist_nxt;
    side_r     <= side_nxt;
    res_st_r   <= res_st_nxt;
    num_r      <= num_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_st_r   <= out_st_nxt;
    out_side_r <= out_side_nxt;
    out_dist_r <= out_dist_nxt;
    out_h_r    <= out_h_nxt;
    out_hx_r   <= out_hx_nxt;
    out_hy_r   <= out_hy_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.hit_face      = out_side_r;
  assign out_ch.perp_distance = out_dist_r;
  assign out_ch.column_height = out_h_r;
  assign out_ch.hit_x         = out_hx_r;
  assign out_ch.hit_y         = out_hy_r;

endmodule

### hdl/dda_rwh_checker.sv
// Port-level checker of the ray caster and its bind to the top level.
module dda_rwh_port_props (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_status,
  input logic [1:0]                         out_side,
  input logic [dda_rwh_pkg::DIST_W-1:0]     out_dist,
  input logic [dda_rwh_pkg::HEIGHT_W-1:0]   out_height,
  input logic [dda_rwh_pkg::CELL_W-1:0]     out_hx,
  input logic [dda_rwh_pkg::CELL_W-1:0]     out_hy
);

  // The map sweep after reset keeps the item channel closed.
  a_reset_closed: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("item channel open straight after reset");

  // One item at a time: an accepted word closes the channel.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in work");

  // Write and no-wall results carry zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != dda_rwh_pkg::ST_HIT) |->
      (out_status == dda_rwh_pkg::ST_WRITTEN || out_status == dda_rwh_pkg::ST_NO_WALL) &&
      out_side == '0 && out_dist == '0 && out_height == '0 && out_hx == '0 && out_hy == '0)
    else $error("non-hit result with bad status or fields");

  // A hit at zero distance gives the saturated height.
  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == dda_rwh_pkg::ST_HIT && out_dist == '0 |-> out_height == '1)
    else $error("zero distance without saturated height");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_dist) &&
      $stable(out_height))
    else $error("stalled result word changed");

endmodule

bind dda_ray_wall_hit_top dda_rwh_port_props u_dda_rwh_port_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_side   (out_ch.hit_face),
  .out_dist   (out_ch.perp_distance),
  .out_height (out_ch.column_height),
  .out_hx     (out_ch.hit_x),
  .out_hy     (out_ch.hit_y)
);
